/* rtl/core/htfd_pkg.sv */
// Shared constants, types and functions for the humidity/temperature frame decoder.
package htfd_pkg;

    localparam int TEMP_W = 15;
    localparam int HUM_W  = 14;
    localparam int RAW_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 15;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;
    localparam logic [2:0] POS_IDLE  = 3'd6;

    localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_MIN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_MAX = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HUM_MAX  = 2'd2;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN_RESET = -15'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX_RESET = 15'sd12500;
    localparam logic [HUM_W-1:0]         HUM_MAX_RESET  = 14'd10000;

    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;

    typedef struct packed {
        logic [RAW_W-1:0] temp_raw;
        logic [RAW_W-1:0] hum_raw;
        logic             temp_ok;
        logic             hum_ok;
    } frame_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_min;
        logic signed [TEMP_W-1:0] temp_max;
        logic [HUM_W-1:0]         hum_max;
    } limits_t;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // floor(p / 65535) via shift-add estimate and one correction
    function automatic logic [15:0] div_65535(input logic [30:0] p);
        logic [31:0] est;
        logic [31:0] rem;
        est = ({1'b0, p} + {17'd0, p[30:16]}) >> 16;
        rem = {1'b0, p} - ((est << 16) - est);
        if (rem >= 32'd65535)
            est = est + 32'd1;
        return est[15:0];
    endfunction

endpackage

/* rtl/core/htfd_if.sv */
// Byte input and result output channel interfaces.
interface htfd_byte_if import htfd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface htfd_result_if import htfd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     temp_crc_ok;
    logic                     hum_crc_ok;
    logic                     updated;
    logic signed [TEMP_W-1:0] temperature_centi;
    logic [HUM_W-1:0]         humidity_centi;

    modport source (output valid, output temp_crc_ok, output hum_crc_ok, output updated,
                    output temperature_centi, output humidity_centi, input ready);
    modport sink   (input valid, input temp_crc_ok, input hum_crc_ok, input updated,
                    input temperature_centi, input humidity_centi, output ready);
endinterface

/* rtl/core/htfd_parser.sv */
// Byte position tracking, running CRC and frame register.
module htfd_parser import htfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    htfd_byte_if.sink    frame_byte,
    output logic         frame_valid,
    output frame_t       frame,
    input  logic         frame_ready
);

    logic [2:0]       pos_reg, pos_next;
    logic [7:0]       crc_reg, crc_next;
    logic [7:0]       high_reg, high_next;
    logic [RAW_W-1:0] traw_reg, traw_next;
    logic [RAW_W-1:0] hraw_reg, hraw_next;
    logic             tok_reg, tok_next;
    logic             fvalid_reg;
    frame_t           frame_reg;

    logic       accept;
    logic       active;
    logic [2:0] pos_cur;
    logic [7:0] crc_step;
    logic       load_frame;
    logic [7:0] b;

    assign b      = frame_byte.data_byte;
    assign accept = frame_byte.valid && frame_byte.ready;
    assign active = frame_byte.frame_start || (pos_reg >= POS_T_LSB && pos_reg <= POS_H_CRC);
    assign pos_cur = frame_byte.frame_start ? POS_T_MSB : pos_reg;
    assign crc_step = crc8_byte((pos_cur == POS_T_MSB || pos_cur == POS_H_MSB) ? CRC_INIT
                                                                               : crc_reg, b);

    always_comb
    begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        high_next  = high_reg;
        traw_next  = traw_reg;
        hraw_next  = hraw_reg;
        tok_next   = tok_reg;
        load_frame = 1'b0;
        if (accept && active)
        begin
            case (pos_cur)
                POS_T_MSB, POS_H_MSB:
                begin
                    crc_next  = crc_step;
                    high_next = b;
                    pos_next  = pos_cur + 3'd1;
                end
                POS_T_LSB:
                begin
                    crc_next  = crc_step;
                    traw_next = {high_reg, b};
                    pos_next  = POS_T_CRC;
                end
                POS_T_CRC:
                begin
                    tok_next = (crc_reg == b);
                    crc_next = CRC_INIT;
                    pos_next = POS_H_MSB;
                end
                POS_H_LSB:
                begin
                    crc_next  = crc_step;
                    hraw_next = {high_reg, b};
                    pos_next  = POS_H_CRC;
                end
                default:
                begin
                    crc_next   = CRC_INIT;
                    pos_next   = POS_IDLE;
                    load_frame = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_IDLE;
            crc_reg    <= CRC_INIT;
            high_reg   <= '0;
            traw_reg   <= '0;
            hraw_reg   <= '0;
            tok_reg    <= 1'b0;
            fvalid_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            high_reg <= high_next;
            traw_reg <= traw_next;
            hraw_reg <= hraw_next;
            tok_reg  <= tok_next;
            if (load_frame)
                fvalid_reg <= 1'b1;
            else if (frame_ready)
                fvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_frame)
        begin
            frame_reg.temp_raw <= traw_reg;
            frame_reg.hum_raw  <= hraw_reg;
            frame_reg.temp_ok  <= tok_reg;
            frame_reg.hum_ok   <= (crc_reg == b);
        end
    end

    assign frame_byte.ready = !fvalid_reg || frame_ready;
    assign frame_valid      = fvalid_reg;
    assign frame            = frame_reg;

endmodule

/* rtl/core/htfd_convert.sv */
// Scaling, limit check, held values and result register.
module htfd_convert import htfd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          frame_valid,
    input  frame_t        frame,
    output logic          frame_ready,
    input  limits_t       limits,
    htfd_result_if.source reading
);

    logic        pvalid_reg;
    logic [30:0] tprod_reg;
    logic [29:0] hprod_reg;
    logic        tok_reg;
    logic        hok_reg;

    logic                     ovalid_reg;
    logic                     otok_reg;
    logic                     ohok_reg;
    logic                     oupd_reg;
    logic signed [TEMP_W-1:0] held_temp_reg;
    logic [HUM_W-1:0]         held_hum_reg;

    logic                     en2, en3;
    logic [15:0]              tq_full, hq_full;
    logic signed [15:0]       temp_calc;
    logic [HUM_W-1:0]         hum_calc;
    logic                     in_limits;
    logic                     upd;

    assign en3 = !ovalid_reg || reading.ready;
    assign en2 = !pvalid_reg || en3;
    assign frame_ready = en2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pvalid_reg <= 1'b0;
        else if (en2)
            pvalid_reg <= frame_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en2 && frame_valid)
        begin
            tprod_reg <= {15'd0, frame.temp_raw} * {16'd0, TEMP_SCALE};
            hprod_reg <= {14'd0, frame.hum_raw} * {16'd0, HUM_SCALE};
            tok_reg   <= frame.temp_ok;
            hok_reg   <= frame.hum_ok;
        end
    end

    assign tq_full   = div_65535(tprod_reg);
    assign hq_full   = div_65535({1'b0, hprod_reg});
    assign temp_calc = $signed({1'b0, tq_full[14:0]}) - TEMP_OFFSET;
    assign hum_calc  = hq_full[HUM_W-1:0];
    assign in_limits = (temp_calc >= $signed({limits.temp_min[TEMP_W-1], limits.temp_min}))
                    && (temp_calc <= $signed({limits.temp_max[TEMP_W-1], limits.temp_max}))
                    && (hum_calc <= limits.hum_max);
    assign upd = tok_reg && hok_reg && in_limits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg    <= 1'b0;
            held_temp_reg <= '0;
            held_hum_reg  <= '0;
        end
        else if (en3)
        begin
            ovalid_reg <= pvalid_reg;
            if (pvalid_reg && upd)
            begin
                held_temp_reg <= temp_calc[TEMP_W-1:0];
                held_hum_reg  <= hum_calc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && pvalid_reg)
        begin
            otok_reg <= tok_reg;
            ohok_reg <= hok_reg;
            oupd_reg <= upd;
        end
    end

    assign reading.valid             = ovalid_reg;
    assign reading.temp_crc_ok       = otok_reg;
    assign reading.hum_crc_ok        = ohok_reg;
    assign reading.updated           = oupd_reg;
    assign reading.temperature_centi = held_temp_reg;
    assign reading.humidity_centi    = held_hum_reg;

endmodule

/* rtl/core/humidity_temp_frame_decoder.sv */
// Humidity/temperature frame decoder: six-byte frame, CRC-8 checks, scaling, limits.
// Takes one byte per cycle unless a stalled result backs up the full pipeline.
// From the sixth byte's transfer the result passes the frame, product and result registers.
// Bytes that cause no result leave only parser state behind.
// Reset: parser idle awaiting frame start, CRC 0xFF, held values zero, limits at defaults.
module humidity_temp_frame_decoder import htfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    htfd_byte_if.sink              frame_byte,
    htfd_result_if.source          reading,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    limits_t limits_reg;
    logic    frame_valid;
    frame_t  frame;
    logic    frame_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.temp_min <= TEMP_MIN_RESET;
            limits_reg.temp_max <= TEMP_MAX_RESET;
            limits_reg.hum_max  <= HUM_MAX_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TEMP_MIN: limits_reg.temp_min <= $signed(cfg_data[TEMP_W-1:0]);
                CFG_TEMP_MAX: limits_reg.temp_max <= $signed(cfg_data[TEMP_W-1:0]);
                CFG_HUM_MAX:  limits_reg.hum_max  <= cfg_data[HUM_W-1:0];
                default:      limits_reg <= limits_reg;
            endcase
        end
    end

    htfd_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_byte  (frame_byte),
        .frame_valid (frame_valid),
        .frame       (frame),
        .frame_ready (frame_ready)
    );

    htfd_convert u_convert
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame       (frame),
        .frame_ready (frame_ready),
        .limits      (limits_reg),
        .reading     (reading)
    );

    // an update needs both words to pass their CRC
    a_upd_needs_crc: assert property (@(posedge clk) disable iff (!rst_n)
        reading.valid && reading.updated |-> reading.temp_crc_ok && reading.hum_crc_ok)
        else $error("update without both CRCs good");

    a_upd_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        reading.valid && reading.updated
        |-> reading.temperature_centi >= limits_reg.temp_min
            && reading.temperature_centi <= limits_reg.temp_max
            && reading.humidity_centi <= limits_reg.hum_max)
        else $error("updated value outside limits");

    // input stalls only when the whole pipeline is full behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_byte.ready |-> reading.valid && !reading.ready && frame_valid)
        else $error("byte input stalled without downstream backpressure");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        reading.valid |-> reading.humidity_centi <= HUM_MAX_RESET)
        else $error("held humidity above full scale");

endmodule

/* tb/tb.sv */
// Self-checking bench for the frame decoder: directed table, random frames, limit changes.
module tb import htfd_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic                     temp_ok;
        logic                     hum_ok;
        logic                     upd;
        logic signed [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]         hum;
    } reading_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] t_lo;
        logic [CFG_DATA_W-1:0] t_hi;
        logic [CFG_DATA_W-1:0] h_hi;
    } limit_words_t;

    typedef enum logic {ROW_BYTE, ROW_LIMITS} row_kind_t;

    typedef struct packed {
        row_kind_t    kind;
        logic [7:0]   b;
        logic         s;
        logic         typed;
        reading_t     want;
        limit_words_t words;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    htfd_byte_if   byte_ch ();
    htfd_result_if reading_ch ();

    humidity_temp_frame_decoder dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_byte (byte_ch),
        .reading    (reading_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // decoder model state
    logic [2:0]               frame_pos;
    logic [7:0]               frame_crc;
    logic [7:0]               high_byte;
    logic [15:0]              temp_word;
    logic [15:0]              hum_word;
    logic                     temp_word_ok;
    logic signed [TEMP_W-1:0] held_temp;
    logic [HUM_W-1:0]         held_hum;
    int                       limit_lo;
    int                       limit_hi;
    int                       limit_hum;

    reading_t pending_readings [$];
    reading_t mon_want;
    reading_t mon_got;
    int       faults;
    int       cycle_count;
    int       bytes_taken;
    int       burst_left;
    int       stall_left;
    int       rx_mode;
    int       rx_mode_left;

    always #(HALF_PERIOD) clk = ~clk;

    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] din);
        logic [7:0] r;
        r = acc ^ din;
        repeat (8)
            r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        return r;
    endfunction

    // raw word whose scaled value lands close to a given limit
    function automatic logic [15:0] word_near(input int target, input int offset, input int span);
        int raw;
        raw = ((target + offset) * 65535) / span + int'($urandom_range(0, 4)) - 2;
        if (raw < 0)
            raw = 0;
        if (raw > 65535)
            raw = 65535;
        return 16'(raw);
    endfunction

    function automatic stim_row_t byte_row(input logic [7:0] b, input logic s);
        stim_row_t row;
        row = '0;
        row.kind = ROW_BYTE;
        row.b = b;
        row.s = s;
        return row;
    endfunction

    function automatic stim_row_t last_row(input logic [7:0] b, input logic t_ok,
                                           input logic h_ok, input logic upd,
                                           input int t, input int h);
        stim_row_t row;
        row = byte_row(b, 1'b0);
        row.typed = 1'b1;
        row.want = '{t_ok, h_ok, upd, 15'(t), 14'(h)};
        return row;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic s, output bit taken,
                               output bit emits, output reading_t r);
        logic [2:0] p;
        logic       hum_ok;
        int         t_val;
        int         h_val;
        taken = 1'b1;
        emits = 1'b0;
        r = '0;
        p = frame_pos;
        if (s)
            p = POS_T_MSB;
        else if (frame_pos < POS_T_LSB || frame_pos > POS_H_CRC)
            taken = 1'b0;
        if (taken)
        begin
            case (p)
                POS_T_MSB, POS_H_MSB:
                begin
                    frame_crc = crc8_next(CRC_INIT, b);
                    high_byte = b;
                    frame_pos = p + 3'd1;
                end
                POS_T_LSB:
                begin
                    frame_crc = crc8_next(frame_crc, b);
                    temp_word = {high_byte, b};
                    frame_pos = POS_T_CRC;
                end
                POS_T_CRC:
                begin
                    temp_word_ok = (frame_crc == b);
                    frame_crc = CRC_INIT;
                    frame_pos = POS_H_MSB;
                end
                POS_H_LSB:
                begin
                    frame_crc = crc8_next(frame_crc, b);
                    hum_word = {high_byte, b};
                    frame_pos = POS_H_CRC;
                end
                default:
                begin
                    hum_ok = (frame_crc == b);
                    frame_crc = CRC_INIT;
                    frame_pos = POS_IDLE;
                    r.temp_ok = temp_word_ok;
                    r.hum_ok = hum_ok;
                    r.upd = 1'b0;
                    if (temp_word_ok && hum_ok)
                    begin
                        t_val = (17500 * int'(temp_word)) / 65535 - 4500;
                        h_val = (10000 * int'(hum_word)) / 65535;
                        if (t_val >= limit_lo && t_val <= limit_hi && h_val <= limit_hum)
                        begin
                            held_temp = 15'(t_val);
                            held_hum = 14'(h_val);
                            r.upd = 1'b1;
                        end
                    end
                    r.temp = held_temp;
                    r.hum = held_hum;
                    emits = 1'b1;
                end
            endcase
        end
    endtask

    // one byte transfer, with the sender's bursts and gaps
    task automatic push_byte(input logic [7:0] b, input logic s, input logic typed = 1'b0,
                             input reading_t want = '0);
        bit       taken;
        bit       emits;
        reading_t r;
        if (burst_left == 0)
        begin
            byte_ch.valid <= 1'b0;
            byte_ch.data_byte <= 8'($urandom);
            byte_ch.frame_start <= 1'($urandom);
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.frame_start <= s;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        decode_byte(b, s, taken, emits, r);
        if (emits)
            pending_readings.push_back(typed ? want : r);
        if (taken)
            bytes_taken++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        byte_ch.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_limits(input limit_words_t w);
        cfg_we <= 1'b1;
        cfg_index <= CFG_TEMP_MIN;
        cfg_data <= w.t_lo;
        @(negedge clk);
        cfg_index <= CFG_TEMP_MAX;
        cfg_data <= w.t_hi;
        @(negedge clk);
        cfg_index <= CFG_HUM_MAX;
        cfg_data <= w.h_hi;
        @(negedge clk);
        cfg_we <= 1'b0;
        limit_lo = int'($signed(w.t_lo));
        limit_hi = int'($signed(w.t_hi));
        limit_hum = int'(w.h_hi[HUM_W-1:0]);
    endtask

    task automatic send_random_frame();
        logic [7:0]  fr [6];
        logic [15:0] tw;
        logic [15:0] hw;
        logic [7:0]  tc;
        logic [7:0]  hc;
        int          kind;
        int          sel;
        int          n;
        kind = $urandom_range(0, 9);
        if (kind == 8)
        begin
            repeat ($urandom_range(1, 4))
                push_byte(8'($urandom), $urandom_range(0, 4) == 0);
        end
        else
        begin
            sel = $urandom_range(0, 9);
            if (sel < 5)
                tw = 16'($urandom);
            else if (sel == 5)
                tw = {16{1'($urandom)}};
            else if (sel < 8)
                tw = word_near(limit_lo, 4500, 17500);
            else
                tw = word_near(limit_hi, 4500, 17500);
            sel = $urandom_range(0, 9);
            if (sel < 5)
                hw = 16'($urandom);
            else if (sel == 5)
                hw = {16{1'($urandom)}};
            else
                hw = word_near(limit_hum, 0, 10000);
            tc = crc8_next(crc8_next(CRC_INIT, tw[15:8]), tw[7:0]);
            hc = crc8_next(crc8_next(CRC_INIT, hw[15:8]), hw[7:0]);
            if ($urandom_range(0, 6) == 0)
                tc ^= 8'($urandom_range(1, 255));
            if ($urandom_range(0, 6) == 0)
                hc ^= 8'($urandom_range(1, 255));
            fr = '{tw[15:8], tw[7:0], tc, hw[15:8], hw[7:0], hc};
            n = (kind == 7) ? $urandom_range(1, 5) : 6;
            for (int i = 0; i < n; i++)
                push_byte(fr[i], i == 0);
            if (kind == 9)
                repeat ($urandom_range(1, 3))
                    push_byte(8'($urandom), 1'b0);
        end
    endtask

    // receiver: modes of free flow, light stalls and long stalls
    always @(negedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 120);
        end
        else
            rx_mode_left--;
        if (stall_left > 0)
        begin
            stall_left--;
            reading_ch.ready <= 1'b0;
        end
        else if (rx_mode == 0)
            reading_ch.ready <= 1'b1;
        else if ($urandom_range(0, 7) < rx_mode)
        begin
            stall_left = (rx_mode == 3) ? $urandom_range(0, 11) : 0;
            reading_ch.ready <= 1'b0;
        end
        else
            reading_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && reading_ch.valid && reading_ch.ready)
        begin
            mon_got = '{reading_ch.temp_crc_ok, reading_ch.hum_crc_ok, reading_ch.updated,
                        reading_ch.temperature_centi, reading_ch.humidity_centi};
            if (pending_readings.size() == 0)
            begin
                if (faults < REPORT_MAX)
                    $display("unexpected reading: crc %0b/%0b upd %0b T %0d RH %0d",
                             mon_got.temp_ok, mon_got.hum_ok, mon_got.upd,
                             $signed(mon_got.temp), mon_got.hum);
                faults++;
            end
            else
            begin
                mon_want = pending_readings.pop_front();
                if (mon_want.temp_ok !== mon_got.temp_ok || mon_want.hum_ok !== mon_got.hum_ok
                    || mon_want.upd !== mon_got.upd || mon_want.temp !== mon_got.temp
                    || mon_want.hum !== mon_got.hum)
                begin
                    if (faults < REPORT_MAX)
                        $display({"reading mismatch: want crc %0b/%0b upd %0b T %0d RH %0d, ",
                                  "got crc %0b/%0b upd %0b T %0d RH %0d"},
                                 mon_want.temp_ok, mon_want.hum_ok, mon_want.upd,
                                 $signed(mon_want.temp), mon_want.hum,
                                 mon_got.temp_ok, mon_got.hum_ok, mon_got.upd,
                                 $signed(mon_got.temp), mon_got.hum);
                    faults++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        stim_row_t    directed [$];
        limit_words_t w;
        int           lo;
        int           hi;
        int           goal;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_TEMP_MIN;
        cfg_data = '0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.frame_start = 1'b0;
        reading_ch.ready = 1'b0;

        frame_pos = POS_IDLE;
        frame_crc = CRC_INIT;
        high_byte = 8'h00;
        temp_word = 16'h0000;
        hum_word = 16'h0000;
        temp_word_ok = 1'b0;
        held_temp = '0;
        held_hum = '0;
        limit_lo = int'(TEMP_MIN_RESET);
        limit_hi = int'(TEMP_MAX_RESET);
        limit_hum = int'(HUM_MAX_RESET);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // CRC of 0x0000 is 0x81, of 0xFFFF is 0xAC
        directed = '{
            byte_row(8'hA5, 1'b0),
            byte_row(8'h00, 1'b1), byte_row(8'h00, 1'b0), byte_row(8'h81, 1'b0),
            byte_row(8'h00, 1'b0), byte_row(8'h00, 1'b0),
            last_row(8'h81, 1'b1, 1'b1, 1'b0, 0, 0),
            byte_row(8'h5A, 1'b0),
            byte_row(8'hBE, 1'b1), byte_row(8'hEF, 1'b0),
            byte_row(8'h00, 1'b1), byte_row(8'h00, 1'b0), byte_row(8'h81, 1'b0),
            byte_row(8'hFF, 1'b0), byte_row(8'hFF, 1'b0),
            last_row(8'h00, 1'b1, 1'b0, 1'b0, 0, 0),
            '{kind: ROW_LIMITS, words: '{15'(-4500), 15'(13000), 15'(10000)}, default: '0},
            byte_row(8'hFF, 1'b1), byte_row(8'hFF, 1'b0), byte_row(8'hAC, 1'b0),
            byte_row(8'hFF, 1'b0), byte_row(8'hFF, 1'b0),
            last_row(8'hAC, 1'b1, 1'b1, 1'b1, 13000, 10000),
            byte_row(8'h00, 1'b1), byte_row(8'h00, 1'b0), byte_row(8'h81, 1'b0),
            byte_row(8'h00, 1'b0), byte_row(8'h00, 1'b0),
            last_row(8'h81, 1'b1, 1'b1, 1'b1, -4500, 0)
        };

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_LIMITS)
            begin
                wait_idle();
                set_limits(directed[i].words);
            end
            else
                push_byte(directed[i].b, directed[i].s, directed[i].typed, directed[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            lo = int'($urandom_range(0, 17500)) - 4500;
            hi = int'($urandom_range(0, 17500)) - 4500;
            case (ph)
                0: w = '{TEMP_MIN_RESET, TEMP_MAX_RESET, {1'b0, HUM_MAX_RESET}};
                1: w = '{15'(-4500), 15'(13000), 15'(0)};
                2: w = '{15'(13000), 15'(-4500), 15'(10000)};
                3: w = (lo > hi) ? '{15'(hi), 15'(lo), 15'($urandom_range(0, 10000))}
                                 : '{15'(lo), 15'(hi), 15'($urandom_range(0, 10000))};
                4: w = '{15'(lo), 15'(lo), 15'($urandom_range(5000, 10000))};
                5: w = '{15'($urandom), 15'($urandom), 15'($urandom)};
                6: w = '{15'(lo), 15'(hi), 15'($urandom_range(0, 10000))};
                default: w = '{15'(-4500), 15'(13000), 15'($urandom_range(0, 10000))};
            endcase
            wait_idle();
            set_limits(w);
            goal = bytes_taken + PHASE_ITEMS;
            while (bytes_taken < goal)
                send_random_frame();
        end

        wait_idle();
        if (faults == 0 && pending_readings.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
